// ===== hdl/spp_pkg.sv =====
// Shared types and constants for the segment pair proximity test.
package spp_pkg;

  // Verdict codes; the checks take priority in the order facing, parallel, A range, B range, far
  typedef enum logic [2:0] {
    V_HIT      = 3'd0,
    V_FACING   = 3'd1,
    V_OUT_A    = 3'd2,
    V_OUT_B    = 3'd3,
    V_FAR      = 3'd4,
    V_PARALLEL = 3'd5
  } verdict_t;

  // Limb width of the split multiplier and its fixed latency
  localparam int MUL_LIMB = 32;
  localparam int MUL_LAT  = 5;

  // Gap tolerance register
  localparam int          TOL_BITS  = 16;
  localparam logic [15:0] TOL_RESET = 16'd4096;

endpackage

// ===== hdl/spp_dly.sv =====
// Enabled delay line for side data that rides alongside the pipeline.
module spp_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  // shift one stage per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== hdl/spp_mul.sv =====
// Pipelined signed multiplier built from 32x32 limb products, five stages.
module spp_mul import spp_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int L  = MUL_LIMB;
  localparam int NA = (AW + L - 1) / L;
  localparam int NB = (BW + L - 1) / L;
  localparam int PW = (NA + NB) * L;
  localparam int RW = AW + BW;

  logic [AW-1:0]     abs_a;
  logic [BW-1:0]     abs_b;
  logic [NA*L-1:0]   ma;
  logic [NB*L-1:0]   mb;
  logic [3:0]        neg_pipe;
  logic [2*L-1:0]    pp [NA][NB];
  logic [PW-1:0]     row_sum [NA];
  logic [PW-1:0]     row [NA];
  logic [PW-1:0]     tot_sum;
  logic [PW-1:0]     tot;

  // magnitudes; the sign is applied again at the end
  assign abs_a = a[AW-1] ? $unsigned(-a) : $unsigned(a);
  assign abs_b = b[BW-1] ? $unsigned(-b) : $unsigned(b);

  // row sums of the limb products, then the sum of rows
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_sum[i] = row_sum[i] + (PW'(pp[i][j]) << (j * L));
      end
    end
  end

  always_comb begin
    tot_sum = '0;
    for (int i = 0; i < NA; i++) begin
      tot_sum = tot_sum + (row[i] << (i * L));
    end
  end

  // stage 1 magnitudes, 2 limb products, 3 rows, 4 total, 5 signed result
  always_ff @(posedge clk) begin
    if (en) begin
      ma       <= (NA*L)'(abs_a);
      mb       <= (NB*L)'(abs_b);
      neg_pipe <= {neg_pipe[2:0], a[AW-1] ^ b[BW-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= (2*L)'(ma[i*L +: L]) * (2*L)'(mb[j*L +: L]);
        end
      end
      row <= row_sum;
      tot <= tot_sum;
      p   <= neg_pipe[3] ? -$signed(tot[RW-1:0]) : $signed(tot[RW-1:0]);
    end
  end

endmodule

// ===== hdl/spp_front.sv =====
// Front end: unpack points, edge vectors, small products, dot products and the cross product.
module spp_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [7:0][47:0]                 pts,
  output logic signed [2*COORD_BITS+3:0]   nn_dot,
  output logic signed [2*COORD_BITS+3:0]   uu_dot,
  output logic signed [2*COORD_BITS+3:0]   vv_dot,
  output logic signed [2*COORD_BITS+3:0]   uv_dot,
  output logic signed [2*COORD_BITS+3:0]   ru_dot,
  output logic signed [2*COORD_BITS+3:0]   rv_dot,
  output logic signed [2*COORD_BITS+2:0]   w_vec [3],
  output logic signed [COORD_BITS:0]       r_vec [3]
);

  localparam int W  = COORD_BITS;
  localparam int CW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int DW = 2 * W + 4;
  localparam int WW = 2 * W + 3;

  logic [63:0]          word_ext [8];
  logic signed [W-1:0]  crd [8][3];

  logic signed [CW-1:0] u1 [3];
  logic signed [CW-1:0] v1 [3];
  logic signed [CW-1:0] r1 [3];
  logic signed [CW-1:0] na1 [3];
  logic signed [CW-1:0] nb1 [3];

  logic signed [PW-1:0] mnn [3];
  logic signed [PW-1:0] muu [3];
  logic signed [PW-1:0] mvv [3];
  logic signed [PW-1:0] muv [3];
  logic signed [PW-1:0] mru [3];
  logic signed [PW-1:0] mrv [3];
  logic signed [PW-1:0] xa [3];
  logic signed [PW-1:0] xb [3];
  logic signed [CW-1:0] r2 [3];

  // unpack; z bits above bit 47 read as zero on wide coordinates
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word_ext[i] = {16'b0, pts[i]};
      for (int k = 0; k < 3; k++) begin
        crd[i][k] = $signed(word_ext[i][k*W +: W]);
      end
    end
  end

  // stage 1: edge vectors, offset and normal sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u1[k]  <= CW'(crd[1][k]) - CW'(crd[0][k]);
        v1[k]  <= CW'(crd[3][k]) - CW'(crd[2][k]);
        r1[k]  <= CW'(crd[2][k]) - CW'(crd[0][k]);
        na1[k] <= CW'(crd[4][k]) + CW'(crd[5][k]);
        nb1[k] <= CW'(crd[6][k]) + CW'(crd[7][k]);
      end
    end
  end

  // stage 2: per-component products, cross product terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mnn[k] <= PW'(na1[k]) * PW'(nb1[k]);
        muu[k] <= PW'(u1[k]) * PW'(u1[k]);
        mvv[k] <= PW'(v1[k]) * PW'(v1[k]);
        muv[k] <= PW'(u1[k]) * PW'(v1[k]);
        mru[k] <= PW'(r1[k]) * PW'(u1[k]);
        mrv[k] <= PW'(r1[k]) * PW'(v1[k]);
        xa[k]  <= PW'(u1[(k+1)%3]) * PW'(v1[(k+2)%3]);
        xb[k]  <= PW'(u1[(k+2)%3]) * PW'(v1[(k+1)%3]);
        r2[k]  <= r1[k];
      end
    end
  end

  // stage 3: dot products and cross product
  always_ff @(posedge clk) begin
    if (en) begin
      nn_dot <= DW'(mnn[0]) + DW'(mnn[1]) + DW'(mnn[2]);
      uu_dot <= DW'(muu[0]) + DW'(muu[1]) + DW'(muu[2]);
      vv_dot <= DW'(mvv[0]) + DW'(mvv[1]) + DW'(mvv[2]);
      uv_dot <= DW'(muv[0]) + DW'(muv[1]) + DW'(muv[2]);
      ru_dot <= DW'(mru[0]) + DW'(mru[1]) + DW'(mru[2]);
      rv_dot <= DW'(mrv[0]) + DW'(mrv[1]) + DW'(mrv[2]);
      for (int k = 0; k < 3; k++) begin
        w_vec[k] <= WW'(xa[k]) - WW'(xb[k]);
        r_vec[k] <= r2[k];
      end
    end
  end

endmodule

// ===== hdl/segment_pair_proximity_test.sv =====
// Top level of the segment pair proximity test pipeline.
//
//   channel  signals                                   direction
//   input    in_valid/in_ready, seg_*, norm_*          in
//   result   out_valid/out_ready, hit, verdict         out
//   config   cfg_valid/cfg_ready, cfg_data             in
//
// One pair enters per cycle unless a result waits at the output.
// The pipeline holds two rounds of five-stage limb-split multipliers
// (Cramer numerators, then squared gap and length limit) plus five stages.
// Reset clears all valid bits and loads gap_tolerance with 4096.
// When a result waits at the output, every stage holds in place.
module segment_pair_proximity_test import spp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] seg_a_start,
  input  logic [47:0] seg_a_end,
  input  logic [47:0] seg_b_start,
  input  logic [47:0] seg_b_end,
  input  logic [47:0] norm_a_start,
  input  logic [47:0] norm_a_end,
  input  logic [47:0] norm_b_start,
  input  logic [47:0] norm_b_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [2:0]  verdict,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int W  = COORD_BITS;
  localparam int CW = W + 1;
  localparam int DW = 2 * W + 4;
  localparam int WW = 2 * W + 3;
  localparam int NW = 2 * DW + 1;
  localparam int QW = WW + CW;
  localparam int TW = QW + 2;
  localparam int LW = DW + TOL_BITS + 1;
  localparam int TT = 2 * TW;
  localparam int RW = LW + NW;

  // stage positions
  localparam int S_FRONT = 3;
  localparam int S_P1    = S_FRONT + MUL_LAT;
  localparam int S_SUM   = S_P1 + 1;
  localparam int S_P2    = S_SUM + MUL_LAT;
  localparam int S_OUT   = S_P2 + 1;

  logic                 en;
  logic [S_OUT:1]       vld;
  logic [15:0]          gap_tolerance;
  logic [7:0][47:0]     pts;

  logic signed [DW-1:0] nn_dot, uu_dot, vv_dot, uv_dot, ru_dot, rv_dot;
  logic signed [WW-1:0] w_vec [3];
  logic signed [CW-1:0] r_vec [3];

  logic signed [DW-1:0] ma_in [6];
  logic signed [DW-1:0] mb_in [6];
  logic signed [2*DW-1:0] pd [6];
  logic signed [QW-1:0] pq [3];

  logic                 facing4;
  logic signed [DW-1:0] l2;
  logic signed [LW-1:0] l2tol;
  logic                 facing9;
  logic signed [LW-1:0] l2tol9;

  logic signed [NW-1:0] d_det, num_a, num_b;
  logic signed [TW-1:0] t_gap;
  logic signed [NW:0]   nbd;
  logic                 out_a, out_b;
  verdict_t             pre_next;
  logic [2:0]           pre10;
  logic [2:0]           pre14;

  logic signed [TT-1:0] tt;
  logic signed [RW-1:0] rhs;
  logic [RW-1:0]        lhs_ext;
  logic                 far;
  verdict_t             verdict_next;

  // global advance: the output register is free or being emptied
  assign en        = !vld[S_OUT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[S_OUT];
  assign cfg_ready = 1'b1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-1:1], in_valid};
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_tolerance <= TOL_RESET;
    end else if (cfg_valid) begin
      gap_tolerance <= cfg_data;
    end
  end

  assign pts = {norm_b_end, norm_b_start, norm_a_end, norm_a_start,
                seg_b_end, seg_b_start, seg_a_end, seg_a_start};

  spp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .en     (en),
    .pts    (pts),
    .nn_dot (nn_dot),
    .uu_dot (uu_dot),
    .vv_dot (vv_dot),
    .uv_dot (uv_dot),
    .ru_dot (ru_dot),
    .rv_dot (rv_dot),
    .w_vec  (w_vec),
    .r_vec  (r_vec)
  );

  // first round: terms of the determinant and both Cramer numerators
  assign ma_in[0] = uu_dot;  assign mb_in[0] = vv_dot;
  assign ma_in[1] = uv_dot;  assign mb_in[1] = uv_dot;
  assign ma_in[2] = ru_dot;  assign mb_in[2] = vv_dot;
  assign ma_in[3] = rv_dot;  assign mb_in[3] = uv_dot;
  assign ma_in[4] = uu_dot;  assign mb_in[4] = rv_dot;
  assign ma_in[5] = uv_dot;  assign mb_in[5] = ru_dot;

  for (genvar g = 0; g < 6; g++) begin : g_cramer
    spp_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma_in[g]),
      .b   (mb_in[g]),
      .p   (pd[g])
    );
  end

  // first round: w . r component terms
  for (genvar g = 0; g < 3; g++) begin : g_gap
    spp_mul #(.AW(WW), .BW(CW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (w_vec[g]),
      .b   (r_vec[g]),
      .p   (pq[g])
    );
  end

  // side path: facing test, longer squared length times tolerance
  always_ff @(posedge clk) begin
    if (en) begin
      facing4 <= nn_dot[DW-1];
      l2      <= (uu_dot > vv_dot) ? uu_dot : vv_dot;
      l2tol   <= LW'(l2) * LW'($signed({1'b0, gap_tolerance}));
    end
  end

  spp_dly #(.WIDTH(1), .DEPTH(S_SUM - S_FRONT - 1)) u_dly_facing (
    .clk (clk),
    .en  (en),
    .d   (facing4),
    .q   (facing9)
  );

  spp_dly #(.WIDTH(LW), .DEPTH(S_SUM - S_FRONT - 2)) u_dly_limit (
    .clk (clk),
    .en  (en),
    .d   (l2tol),
    .q   (l2tol9)
  );

  // determinant, numerators and the gap term
  always_ff @(posedge clk) begin
    if (en) begin
      d_det <= NW'(pd[0]) - NW'(pd[1]);
      num_a <= NW'(pd[2]) - NW'(pd[3]);
      num_b <= NW'(pd[4]) - NW'(pd[5]);
      t_gap <= TW'(pq[0]) + TW'(pq[1]) + TW'(pq[2]);
    end
  end

  // early verdict from facing, parallel and range checks
  assign nbd   = (NW+1)'(num_b) + (NW+1)'(d_det);
  assign out_a = num_a[NW-1] || (num_a > d_det);
  assign out_b = (!num_b[NW-1] && (num_b != '0)) || nbd[NW];

  always_comb begin
    if (facing9) begin
      pre_next = V_FACING;
    end else if (d_det == '0) begin
      pre_next = V_PARALLEL;
    end else if (out_a) begin
      pre_next = V_OUT_A;
    end else if (out_b) begin
      pre_next = V_OUT_B;
    end else begin
      pre_next = V_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre10 <= pre_next;
    end
  end

  spp_dly #(.WIDTH(3), .DEPTH(S_P2 - S_SUM - 1)) u_dly_pre (
    .clk (clk),
    .en  (en),
    .d   (pre10),
    .q   (pre14)
  );

  // second round: squared gap and the allowed limit
  spp_mul #(.AW(TW), .BW(TW)) u_mul_tt (
    .clk (clk),
    .en  (en),
    .a   (t_gap),
    .b   (t_gap),
    .p   (tt)
  );

  spp_mul #(.AW(LW), .BW(NW)) u_mul_lim (
    .clk (clk),
    .en  (en),
    .a   (l2tol9),
    .b   (d_det),
    .p   (rhs)
  );

  // final compare, scaled squared gap against the limit
  assign lhs_ext = RW'({tt, {TOL_BITS{1'b0}}});
  assign far     = $signed(lhs_ext) > rhs;

  always_comb begin
    if (verdict_t'(pre14) != V_HIT) begin
      verdict_next = verdict_t'(pre14);
    end else if (far) begin
      verdict_next = V_FAR;
    end else begin
      verdict_next = V_HIT;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      hit     <= (verdict_next == V_HIT);
      verdict <= verdict_next;
    end
  end

`ifndef SYNTHESIS
  // pipeline is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // a waiting result freezes the valid bits of every stage
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(vld))
    else $error("pipeline moved during stall");

  // hit agrees with the verdict code
  a_hit_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit == (verdict == 3'(V_HIT))))
    else $error("hit and verdict disagree");
`endif

endmodule

// ===== verif/spp_checker.sv =====
// Checker for the segment pair proximity test: predicts each verdict and compares results.
module spp_checker import spp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [47:0] seg_a_start,
  input  logic [47:0] seg_a_end,
  input  logic [47:0] seg_b_start,
  input  logic [47:0] seg_b_end,
  input  logic [47:0] norm_a_start,
  input  logic [47:0] norm_a_end,
  input  logic [47:0] norm_b_start,
  input  logic [47:0] norm_b_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        hit,
  input  logic [2:0]  verdict,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          pairs_in,
  output int          results_out,
  output int          hits_out,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for squared gap times 2^16 and length * tolerance * det
  typedef logic signed [255:0] wide_t;

  logic [15:0] gap_tol;
  verdict_t    verdicts_due[$];
  int          fail_cnt = 0;

  assign mismatches = fail_cnt;

  // Signed coordinate k of a packed point; bits above 47 read as zero
  function automatic longint coord(logic [47:0] word, int k);
    logic [63:0] raw;
    longint      val;
    raw = ({16'd0, word} >> (k * COORD_BITS)) & ((64'd1 << COORD_BITS) - 64'd1);
    val = longint'(raw);
    if (raw[COORD_BITS-1]) val -= longint'(1) << COORD_BITS;
    return val;
  endfunction

  // Verdict for one segment pair; word i of pts is field i, seg_a_start first
  function automatic verdict_t judge_pair(logic [8*48-1:0] pts, logic [15:0] tol);
    longint p[8][3];
    longint u[3], v[3], r[3], w[3], na[3], nb[3];
    longint uu, vv, uv, ru, rv, l2, facing;
    wide_t  det, num_a, num_b, perp, lhs, rhs;
    for (int i = 0; i < 8; i++)
      for (int k = 0; k < 3; k++)
        p[i][k] = coord(pts[i*48 +: 48], k);
    for (int k = 0; k < 3; k++) begin
      na[k] = p[4][k] + p[5][k];
      nb[k] = p[6][k] + p[7][k];
      u[k]  = p[1][k] - p[0][k];
      v[k]  = p[3][k] - p[2][k];
      r[k]  = p[2][k] - p[0][k];
    end
    // summed normals pointing away from each other
    facing = na[0]*nb[0] + na[1]*nb[1] + na[2]*nb[2];
    if (facing < 0) return V_FACING;

    uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    ru = r[0]*u[0] + r[1]*u[1] + r[2]*u[2];
    rv = r[0]*v[0] + r[1]*v[1] + r[2]*v[2];

    // Cramer determinant; zero means parallel or zero length
    det = wide_t'(uu) * wide_t'(vv) - wide_t'(uv) * wide_t'(uv);
    if (det == 0) return V_PARALLEL;

    // a scaled by det must lie in [0, det]
    num_a = wide_t'(ru) * wide_t'(vv) - wide_t'(rv) * wide_t'(uv);
    if (num_a < 0 || num_a > det) return V_OUT_A;

    // b scaled by det must lie in [-det, 0]
    num_b = wide_t'(uu) * wide_t'(rv) - wide_t'(uv) * wide_t'(ru);
    if (num_b > 0 || num_b < -det) return V_OUT_B;

    // perpendicular gap: (w.r)^2 / |w|^2 against longer length * tol / 2^16
    w[0] = u[1]*v[2] - u[2]*v[1];
    w[1] = u[2]*v[0] - u[0]*v[2];
    w[2] = u[0]*v[1] - u[1]*v[0];
    perp = wide_t'(w[0]) * wide_t'(r[0]) + wide_t'(w[1]) * wide_t'(r[1])
         + wide_t'(w[2]) * wide_t'(r[2]);
    l2   = (uu > vv) ? uu : vv;
    lhs  = perp * perp * wide_t'(65536);
    rhs  = wide_t'(l2) * wide_t'(longint'(tol)) * det;
    if (lhs > rhs) return V_FAR;
    return V_HIT;
  endfunction

  // Track register writes, queue predictions, check results in order
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      gap_tol     <= TOL_RESET;
      verdicts_due.delete();
      pairs_in    <= 0;
      results_out <= 0;
      hits_out    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) gap_tol <= cfg_data;

      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result transfer with no pair outstanding: hit=%0d verdict=%0d",
                 hit, verdict);
          fail_cnt++;
        end else begin
          want = verdicts_due.pop_front();
          if (hit !== (want == V_HIT)) begin
            $error("hit mismatch: expected %0d, actual %0d", want == V_HIT, hit);
            fail_cnt++;
          end
          if (verdict !== want) begin
            $error("verdict mismatch: expected %0d, actual %0d", want, verdict);
            fail_cnt++;
          end
        end
        results_out <= results_out + 1;
        if (hit) hits_out <= hits_out + 1;
      end

      if (in_valid && in_ready) begin
        verdicts_due.push_back(judge_pair({norm_b_end, norm_b_start, norm_a_end,
                                           norm_a_start, seg_b_end, seg_b_start,
                                           seg_a_end, seg_a_start}, gap_tol));
        pairs_in <= pairs_in + 1;
      end
    end
  end

endmodule

// ===== verif/tb_segment_pair_proximity_test.sv =====
// Testbench top for the segment pair proximity test: stimulus, idling and verdict.
module tb_segment_pair_proximity_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS   = 16;
  localparam int PHASE_PAIRS  = 205;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [47:0] seg_a_start = '0;
  logic [47:0] seg_a_end = '0;
  logic [47:0] seg_b_start = '0;
  logic [47:0] seg_b_end = '0;
  logic [47:0] norm_a_start = '0;
  logic [47:0] norm_a_end = '0;
  logic [47:0] norm_b_start = '0;
  logic [47:0] norm_b_end = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [2:0]  verdict;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int pairs_in, results_out, hits_out, mismatches;
  int idle_cycles = 0;
  int tol_settings = 1;
  bit calm = 1'b0;

  segment_pair_proximity_test #(.COORD_BITS(COORD_BITS)) dut (.*);

  spp_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side stalls about 36% of cycles except during calm stretches
  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 36);

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** segment_pair_proximity_test: FAILED **");
      $finish;
    end
  end

  function automatic logic [47:0] pack3(int x, int y, int z);
    logic [63:0] mask, word;
    mask = (64'd1 << COORD_BITS) - 64'd1;
    word = (64'(x) & mask) | ((64'(y) & mask) << COORD_BITS)
         | ((64'(z) & mask) << (2 * COORD_BITS));
    return word[47:0];
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] word;
    word = {$urandom, $urandom};
    return word[47:0];
  endfunction

  function automatic int span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // One pair transfer, with random idle cycles ahead of it
  task automatic send_pair(input logic [47:0] a0, a1, b0, b1, n0, n1, n2, n3);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    seg_a_start  <= a0;
    seg_a_end    <= a1;
    seg_b_start  <= b0;
    seg_b_end    <= b1;
    norm_a_start <= n0;
    norm_a_end   <= n1;
    norm_b_start <= n2;
    norm_b_end   <= n3;
    do @(posedge clk); while (!in_ready);
  endtask

  // A runs (0,0,0)..(256,0,0); B runs along y at x = bx, height h
  task automatic send_cross(input int bx, by0, by1, h, input logic [47:0] nrm_a, nrm_b);
    send_pair(pack3(0, 0, 0), pack3(256, 0, 0), pack3(bx, by0, h), pack3(bx, by1, h),
              nrm_a, nrm_a, nrm_b, nrm_b);
  endtask

  // Segments built to meet near a common point, or plain noise
  task automatic send_random_pair();
    int kind, sc_u, sc_v, ka, kb, jit, dot;
    int x[3], u[3], v[3], a0[3], b0[3], jt[3];
    int n[4][3];
    kind = $urandom_range(99);
    if (kind < 18) begin
      send_pair(rand48(), rand48(), rand48(), rand48(),
                rand48(), rand48(), rand48(), rand48());
      return;
    end
    case ($urandom_range(2))
      0:       sc_u = 8;
      1:       sc_u = 255;
      default: sc_u = 4000;
    endcase
    case ($urandom_range(2))
      0:       sc_v = 8;
      1:       sc_v = 255;
      default: sc_v = 4000;
    endcase
    case ($urandom_range(3))
      0:       jit = 0;
      1:       jit = 2;
      2:       jit = 40;
      default: jit = 600;
    endcase
    ka = int'($urandom_range(296)) - 20;
    kb = int'($urandom_range(296)) - 20;
    for (int k = 0; k < 3; k++) begin
      x[k]  = span(8000);
      u[k]  = span(sc_u);
      v[k]  = span(sc_v);
      jt[k] = span(jit);
    end
    // occasional parallel or antiparallel second segment
    if (kind >= 96)
      for (int k = 0; k < 3; k++) v[k] = u[k] * ((kind & 1) ? -2 : 1);
    for (int k = 0; k < 3; k++) begin
      a0[k] = x[k] - (u[k] * ka) / 256;
      b0[k] = x[k] - (v[k] * kb) / 256 + jt[k];
    end
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        n[i][k] = span(16383);
    dot = 0;
    for (int k = 0; k < 3; k++) dot += (n[0][k] + n[1][k]) * (n[2][k] + n[3][k]);
    // most pairs get compatible normals so they reach the later checks
    if (kind >= 28 && dot < 0)
      for (int k = 0; k < 3; k++) begin
        n[2][k] = -n[2][k];
        n[3][k] = -n[3][k];
      end
    send_pair(pack3(a0[0], a0[1], a0[2]),
              pack3(a0[0] + u[0], a0[1] + u[1], a0[2] + u[2]),
              pack3(b0[0], b0[1], b0[2]),
              pack3(b0[0] + v[0], b0[1] + v[1], b0[2] + v[2]),
              pack3(n[0][0], n[0][1], n[0][2]), pack3(n[1][0], n[1][1], n[1][2]),
              pack3(n[2][0], n[2][1], n[2][2]), pack3(n[3][0], n[3][1], n[3][2]));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pairs_in != results_out) @(posedge clk);
  endtask

  task automatic set_gap_tolerance(input logic [15:0] value);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_settings++;
  endtask

  initial begin
    logic [47:0] nz, nmax, nmin;
    logic [15:0] tol_plan[6];
    nz   = pack3(0, 0, 16384);
    nmax = pack3(32767, 32767, 32767);
    nmin = pack3(-32768, -32768, -32768);
    tol_plan = '{16'd0, 16'hFFFF, 16'(($urandom)), 16'd1, 16'(($urandom)), 16'h8000};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs under the reset tolerance
    send_pair('0, '0, '0, '0, '0, '0, '0, '0);
    send_pair('1, '1, '1, '1, '1, '1, '1, '1);
    send_pair(nmin, pack3(32767, 32767, -32768), pack3(32767, -32768, 32767),
              pack3(-32768, 32767, 32767), nmin, nmin, nmin, nmin);
    send_pair(nmin, pack3(32767, 32767, -32768), pack3(32767, -32768, 32767),
              pack3(-32768, 32767, 32767), nmax, nmax, nmax, nmax);
    send_cross(128, -128, 128, 0, nz, nz);
    send_cross(128, -128, 128, 0, nz, pack3(0, 0, -16384));  // normals facing apart
    send_cross(128, -128, 128, 0, nz, pack3(16384, 0, 0));   // normals at right angles
    send_cross(0, -128, 128, 0, nz, nz);       // a exactly 0
    send_cross(256, -128, 128, 0, nz, nz);     // a exactly 1
    send_cross(-1, -128, 128, 0, nz, nz);      // a just below 0
    send_cross(257, -128, 128, 0, nz, nz);     // a just above 1
    send_cross(128, 0, 256, 0, nz, nz);        // b exactly 0
    send_cross(128, 1, 257, 0, nz, nz);        // b just above 0
    send_cross(128, -256, 0, 0, nz, nz);       // b exactly -1
    send_cross(128, -257, -1, 0, nz, nz);      // b just below -1
    send_cross(128, -128, 128, 64, nz, nz);    // gap equal to the limit
    send_cross(128, -128, 128, 65, nz, nz);    // gap just past the limit
    send_cross(128, -128, 128, -64, nz, nz);
    send_cross(128, 7, 7, 0, nz, nz);          // zero length second segment
    send_pair(pack3(0, 0, 0), pack3(256, 0, 0), pack3(0, 5, 0), pack3(512, 5, 0),
              nz, nz, nz, nz);                 // parallel, both nonzero

    // Random pairs across several gap tolerance settings
    foreach (tol_plan[ph]) begin
      set_gap_tolerance(tol_plan[ph]);
      for (int i = 0; i < PHASE_PAIRS; i++) begin
        calm = (ph == 2 && i < 120);
        send_random_pair();
      end
      calm = 1'b0;
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Judged %0d segment pairs under %0d gap tolerance settings, %0d of them hits.",
             results_out, tol_settings, hits_out);
    if (mismatches == 0 && pairs_in == results_out)
      $display("** segment_pair_proximity_test: PASSED **");
    else
      $display("** segment_pair_proximity_test: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/spp_pkg.sv
hdl/spp_dly.sv
hdl/spp_mul.sv
hdl/spp_front.sv
hdl/segment_pair_proximity_test.sv
verif/spp_checker.sv
verif/tb_segment_pair_proximity_test.sv
